// ===== rtl/bmp24_pkg.sv =====
// bmp24_pkg: shared constants, codes and item types of the bmp24 stream decoder
// no dependencies; used by the channel interfaces and all rtl modules

package bmp24_pkg;

   // default bound on image width and height
   localparam int unsigned MAX_DIM_DEFAULT = 4096;

   // field widths of the channels
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned ERR_W   = 3;
   localparam int unsigned IMGD_W  = 13;
   localparam int unsigned BPP_W   = 16;
   localparam int unsigned COORD_W = 12;

   // header layout
   localparam logic [31:0] HDR_LEN = 32'd54;
   localparam logic [BYTE_W-1:0] SIG_B = 8'h42;
   localparam logic [BYTE_W-1:0] SIG_M = 8'h4D;
   localparam logic [BPP_W-1:0] DEPTH_24 = 16'd24;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_SIGNATURE   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_COMPRESSION = 3'd2;
   localparam logic [ERR_W-1:0] ERR_PALETTE     = 3'd3;
   localparam logic [ERR_W-1:0] ERR_SHORT_HDR   = 3'd4;
   localparam logic [ERR_W-1:0] ERR_SHORT_PIX   = 3'd5;
   localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 3'd6;
   localparam logic [ERR_W-1:0] ERR_OFFSET      = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_file;
   } in_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ERR_W-1:0]   error_code;
      logic [IMGD_W-1:0]  image_width;
      logic [IMGD_W-1:0]  image_height;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [COORD_W-1:0] pixel_column;
      logic [COORD_W-1:0] pixel_row;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  red;
      logic               last_pixel;
   } result_type;

endpackage

// ===== rtl/bmp24_stream_if.sv =====
// bmp24 channel interfaces: byte request channel and result channel
// depends on bmp24_pkg for field widths

interface bmp24_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmp24_pkg::BYTE_W-1:0]     data_byte;
   logic                             end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface bmp24_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bmp24_pkg::KIND_W-1:0]     kind;
   logic [bmp24_pkg::ERR_W-1:0]      error_code;
   logic [bmp24_pkg::IMGD_W-1:0]     image_width;
   logic [bmp24_pkg::IMGD_W-1:0]     image_height;
   logic [bmp24_pkg::BPP_W-1:0]      bits_per_pixel;
   logic [bmp24_pkg::COORD_W-1:0]    pixel_column;
   logic [bmp24_pkg::COORD_W-1:0]    pixel_row;
   logic [bmp24_pkg::BYTE_W-1:0]     blue;
   logic [bmp24_pkg::BYTE_W-1:0]     green;
   logic [bmp24_pkg::BYTE_W-1:0]     red;
   logic                             last_pixel;

   modport source (output valid, output kind, output error_code, output image_width,
                   output image_height, output bits_per_pixel, output pixel_column,
                   output pixel_row, output blue, output green, output red,
                   output last_pixel, input ready);
   modport sink (input valid, input kind, input error_code, input image_width,
                 input image_height, input bits_per_pixel, input pixel_column,
                 input pixel_row, input blue, input green, input red,
                 input last_pixel, output ready);
endinterface

// ===== rtl/bmp24_in_stage.sv =====
// bmp24_in_stage: input register of the byte channel
// depends on bmp24_pkg and bmp24_req_if

module bmp24_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   bmp24_req_if.sink              req_ch,
   input  logic                   take,
   output logic                   item_valid,
   output bmp24_pkg::in_item_type item
);

   logic                   valid_ff, valid_in;
   bmp24_pkg::in_item_type item_ff;
   logic                   load;

   assign req_ch.ready = !valid_ff || take;
   assign load = req_ch.valid && req_ch.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte   <= req_ch.data_byte;
         item_ff.end_of_file <= req_ch.end_of_file;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/bmp24_decode.sv =====
// bmp24_decode: header parse, offset skip, pixel assembly and row padding state
// depends on bmp24_pkg; one byte is decoded per step

module bmp24_decode #(
   parameter int unsigned MAX_DIM = bmp24_pkg::MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bmp24_pkg::in_item_type item,
   output logic                   res_valid,
   output bmp24_pkg::result_type  res
);

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam int unsigned CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_PIXEL  = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_IDLE   = 3'd4;

   // control state
   logic [2:0]       phase_ff, phase_in;
   logic [31:0]      pos_ff, pos_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [1:0]       bip_ff, bip_in;
   logic [1:0]       pad_ff, pad_in;

   // header fields and held components
   logic [31:0]      field_ff, field_in;
   logic [31:0]      offset_ff, offset_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             width_big_ff, width_big_in;
   logic             height_big_ff, height_big_in;
   logic [15:0]      depth_ff, depth_in;
   logic [7:0]       blue_ff, blue_in;
   logic [7:0]       green_ff, green_in;

   always_comb begin
      logic [7:0]       b;
      logic             eof;
      logic [5:0]       hp;
      logic             tracked;
      logic [1:0]       k;
      logic [31:0]      fs;
      logic             err;
      logic [2:0]       err_code;
      logic             fin;
      logic             expects;
      logic             last;
      logic             col_end;

      b        = item.data_byte;
      eof      = item.end_of_file;
      hp       = pos_ff[5:0];
      tracked  = (hp inside {[10:13], [18:25], [28:33], [46:49]});
      k        = (hp inside {[28:29]}) ? hp[1:0] : hp[1:0] - 2'd2;
      fs       = (k == 2'd0) ? 32'(b) : (field_ff | (32'(b) << {k, 3'b000}));
      err      = 1'b0;
      err_code = bmp24_pkg::ERR_NONE;
      fin      = 1'b0;
      expects  = (depth_ff == bmp24_pkg::DEPTH_24) && (width_ff != '0) && (height_ff != '0);
      last     = (DIM_W'(col_ff) + DIM_W'(1) == width_ff)
                 && (DIM_W'(row_ff) + DIM_W'(1) == height_ff);
      col_end  = (DIM_W'(col_ff) + DIM_W'(1) >= width_ff);

      phase_in      = phase_ff;
      pos_in        = pos_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bip_in        = bip_ff;
      pad_in        = pad_ff;
      field_in      = field_ff;
      offset_in     = offset_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      width_big_in  = width_big_ff;
      height_big_in = height_big_ff;
      depth_in      = depth_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               if ((hp == 6'd0 && b != bmp24_pkg::SIG_B)
                   || (hp == 6'd1 && b != bmp24_pkg::SIG_M)) begin
                  err      = 1'b1;
                  err_code = bmp24_pkg::ERR_SIGNATURE;
               end else begin
                  if (tracked) begin
                     field_in = fs;
                  end
                  if (hp == 6'd13) begin
                     offset_in = fs;
                  end
                  if (hp == 6'd21) begin
                     width_in     = DIM_W'(fs);
                     width_big_in = fs > 32'(MAX_DIM);
                  end
                  if (hp == 6'd25) begin
                     height_in     = DIM_W'(fs);
                     height_big_in = fs > 32'(MAX_DIM);
                  end
                  if (hp == 6'd29) begin
                     depth_in = fs[15:0];
                  end
                  if (hp == 6'd33 && fs != '0) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_COMPRESSION;
                  end else if (hp == 6'd49 && fs != '0) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_PALETTE;
                  end else if (hp != 6'(bmp24_pkg::HDR_LEN - 32'd1)) begin
                     if (eof) begin
                        err      = 1'b1;
                        err_code = bmp24_pkg::ERR_SHORT_HDR;
                     end else begin
                        pos_in = pos_ff + 32'd1;
                     end
                  end else if (width_big_ff || height_big_ff) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_TOO_LARGE;
                  end else if (offset_ff < bmp24_pkg::HDR_LEN) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_OFFSET;
                  end else if (expects && eof) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_SHORT_PIX;
                  end else begin
                     res_valid          = 1'b1;
                     res.kind           = bmp24_pkg::KIND_HEADER;
                     res.image_width    = 13'(width_ff);
                     res.image_height   = 13'(height_ff);
                     res.bits_per_pixel = depth_ff;
                     if (!expects) begin
                        fin = 1'b1;
                     end else begin
                        pos_in   = bmp24_pkg::HDR_LEN;
                        col_in   = '0;
                        row_in   = '0;
                        bip_in   = 2'd0;
                        pad_in   = 2'd0;
                        phase_in = (offset_ff == bmp24_pkg::HDR_LEN) ? PH_PIXEL : PH_SKIP;
                     end
                  end
               end
            end
            PH_SKIP: begin
               pos_in = pos_ff + 32'd1;
               if (eof) begin
                  err      = 1'b1;
                  err_code = bmp24_pkg::ERR_SHORT_PIX;
               end else if (pos_ff + 32'd1 == offset_ff) begin
                  phase_in = PH_PIXEL;
               end
            end
            PH_PIXEL: begin
               case (bip_ff)
                  2'd0: begin
                     blue_in = b;
                     bip_in  = 2'd1;
                  end
                  2'd1: begin
                     green_in = b;
                     bip_in   = 2'd2;
                  end
                  default: begin
                     bip_in = 2'd0;
                  end
               endcase
               if (bip_ff != 2'd2 || !last) begin
                  if (eof) begin
                     err      = 1'b1;
                     err_code = bmp24_pkg::ERR_SHORT_PIX;
                  end
               end
               if (bip_ff == 2'd2 && !err) begin
                  res_valid        = 1'b1;
                  res.kind         = bmp24_pkg::KIND_PIXEL;
                  res.pixel_column = 12'(col_ff);
                  res.pixel_row    = 12'(height_ff - DIM_W'(1) - DIM_W'(row_ff));
                  res.blue         = blue_ff;
                  res.green        = green_ff;
                  res.red          = b;
                  res.last_pixel   = last;
                  if (last) begin
                     fin = 1'b1;
                  end else if (col_end) begin
                     col_in = '0;
                     row_in = row_ff + CNT_W'(1);
                     pad_in = 2'(width_ff);
                     if (2'(width_ff) != 2'd0) begin
                        phase_in = PH_PAD;
                     end
                  end else begin
                     col_in = col_ff + CNT_W'(1);
                  end
               end
            end
            PH_PAD: begin
               if (eof) begin
                  err      = 1'b1;
                  err_code = bmp24_pkg::ERR_SHORT_PIX;
               end else begin
                  pad_in = pad_ff - 2'd1;
                  if (pad_ff == 2'd1) begin
                     phase_in = PH_PIXEL;
                  end
               end
            end
            default: begin
               fin = eof;
            end
         endcase

         if (err) begin
            fin            = 1'b1;
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = bmp24_pkg::KIND_ERROR;
            res.error_code = err_code;
         end

         // finished file: back to reset state on end of file, else ignore bytes
         if (fin) begin
            if (eof) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
               col_in   = '0;
               row_in   = '0;
               bip_in   = 2'd0;
               pad_in   = 2'd0;
               field_in = '0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         bip_ff   <= 2'd0;
         pad_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      field_ff      <= field_in;
      offset_ff     <= offset_in;
      width_ff      <= width_in;
      height_ff     <= height_in;
      width_big_ff  <= width_big_in;
      height_big_ff <= height_big_in;
      depth_ff      <= depth_in;
      blue_ff       <= blue_in;
      green_ff      <= green_in;
   end

endmodule

// ===== rtl/bmp24_stream_decoder.sv =====
// bmp24_stream_decoder: 24 bpp bitmap decoder; an accepted item is held in the input
// register and decoded into the result register by a decode step; one item per cycle
// unless the result side stalls, set by the single decode step between the two registers
// synchronous active-high reset clears the input and result valids and the decoder state
// depends on bmp24_pkg, bmp24_stream_if, bmp24_in_stage and bmp24_decode

module bmp24_stream_decoder #(
   parameter int unsigned MAX_DIM = bmp24_pkg::MAX_DIM_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   bmp24_req_if.sink    req_ch,
   bmp24_rsp_if.source  rsp_ch
);

   // input register outputs
   logic                   item_valid;
   bmp24_pkg::in_item_type item;

   // decode step results
   logic                   res_valid;
   bmp24_pkg::result_type  res;

   // result register
   logic                   out_valid_ff, out_valid_in;
   bmp24_pkg::result_type  out_ff;

   // a byte is decoded whenever the result register is free or being emptied;
   // bytes that produce no result still pass through and leave the result register empty
   logic                   step;

   assign step = item_valid && (!out_valid_ff || rsp_ch.ready);

   bmp24_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   bmp24_decode #(
      .MAX_DIM (MAX_DIM)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register: loaded on a decode step, drained by the sink
   always_comb begin
      if (step) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.error_code     = out_ff.error_code;
   assign rsp_ch.image_width    = out_ff.image_width;
   assign rsp_ch.image_height   = out_ff.image_height;
   assign rsp_ch.bits_per_pixel = out_ff.bits_per_pixel;
   assign rsp_ch.pixel_column   = out_ff.pixel_column;
   assign rsp_ch.pixel_row      = out_ff.pixel_row;
   assign rsp_ch.blue           = out_ff.blue;
   assign rsp_ch.green          = out_ff.green;
   assign rsp_ch.red            = out_ff.red;
   assign rsp_ch.last_pixel     = out_ff.last_pixel;

`ifndef SYNTHESIS
   // a held input byte is not lost while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !step) |=> (item_valid && $stable(item)))
      else $error("input byte dropped during stall");

   // a pending result is never overwritten by a new decode step
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("pending result overwritten");

   // error results carry a code and no header or pixel payload
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == bmp24_pkg::KIND_ERROR)
      |-> (out_ff.error_code != bmp24_pkg::ERR_NONE && out_ff.image_width == '0
           && out_ff.pixel_column == '0 && out_ff.last_pixel == 1'b0))
      else $error("malformed error result");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !item_valid))
      else $error("valid state survived reset");
`endif

endmodule

// ===== bench/bmp24_decode_check_pkg.sv =====
// bmp24_decode_check_pkg: bit-exact predictor and result checker for the bmp24 stream decoder
// depends on bmp24_pkg for field widths, result kinds and error codes

package bmp24_decode_check_pkg;
   import bmp24_pkg::*;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   typedef enum logic [2:0] {ST_HEADER, ST_SKIP, ST_PIXEL, ST_PAD, ST_IDLE} parse_stage_type;

   class bmp_decode_scoreboard;
      int fail_count;
      result_type decoded_results[$];

      // predictor state, kept at the widths the decoding arithmetic needs
      parse_stage_type stage;
      int unsigned hdr_pos;
      int unsigned field_acc;
      int unsigned width_val;
      int unsigned height_val;
      int unsigned data_offset;
      int unsigned col_idx;
      int unsigned row_idx;
      logic [BPP_W-1:0] depth_val;
      logic [1:0] byte_slot;
      logic [1:0] pad_count;
      logic [BYTE_W-1:0] blue_hold;
      logic [BYTE_W-1:0] green_hold;

      function new();
         fail_count = 0;
         clear_state();
      endfunction

      function void clear_state();
         stage = ST_HEADER;
         hdr_pos = 0;
         field_acc = 0;
         width_val = 0;
         height_val = 0;
         data_offset = 0;
         col_idx = 0;
         row_idx = 0;
         depth_val = '0;
         byte_slot = '0;
         pad_count = '0;
         blue_hold = '0;
         green_hold = '0;
      endfunction

      // end of file restarts, anything else waits for it
      function void end_file(logic eof);
         if (eof) clear_state();
         else stage = ST_IDLE;
      endfunction

      function void post_error(logic [ERR_W-1:0] code, logic eof);
         result_type r;
         r = '0;
         r.kind = KIND_ERROR;
         r.error_code = code;
         decoded_results.push_back(r);
         end_file(eof);
      endfunction

      function void decode_byte(logic [BYTE_W-1:0] b, logic eof);
         result_type r;
         int unsigned pos;
         int unsigned st;
         int unsigned k;
         bit expects;
         bit last;
         r = '0;
         case (stage)
            ST_HEADER: begin
               pos = hdr_pos;
               if ((pos == 0 && b != SIG_B) || (pos == 1 && b != SIG_M)) begin
                  post_error(ERR_SIGNATURE, eof);
                  return;
               end
               if (pos >= 10 && pos <= 13) st = 10;
               else if (pos >= 18 && pos <= 21) st = 18;
               else if (pos >= 22 && pos <= 25) st = 22;
               else if (pos >= 28 && pos <= 29) st = 28;
               else if (pos >= 30 && pos <= 33) st = 30;
               else if (pos >= 46 && pos <= 49) st = 46;
               else st = HDR_LEN;
               if (st < HDR_LEN) begin
                  k = (pos - st) & 3;
                  if (k == 0) field_acc = 32'(b);
                  else field_acc |= 32'(b) << (8 * k);
                  if (pos == 13) data_offset = field_acc;
                  if (pos == 21) width_val = field_acc;
                  if (pos == 25) height_val = field_acc;
                  if (pos == 29) depth_val = field_acc[BPP_W-1:0];
                  if (pos == 33 && field_acc != 0) begin
                     post_error(ERR_COMPRESSION, eof);
                     return;
                  end
                  if (pos == 49 && field_acc != 0) begin
                     post_error(ERR_PALETTE, eof);
                     return;
                  end
               end
               if (pos != HDR_LEN - 1) begin
                  if (eof) post_error(ERR_SHORT_HDR, eof);
                  else hdr_pos = pos + 1;
                  return;
               end
               if (width_val > MAX_DIM_DEFAULT || height_val > MAX_DIM_DEFAULT) begin
                  post_error(ERR_TOO_LARGE, eof);
                  return;
               end
               if (data_offset < HDR_LEN) begin
                  post_error(ERR_OFFSET, eof);
                  return;
               end
               expects = depth_val == DEPTH_24 && width_val != 0 && height_val != 0;
               if (expects && eof) begin
                  post_error(ERR_SHORT_PIX, eof);
                  return;
               end
               r.kind = KIND_HEADER;
               r.image_width = width_val[IMGD_W-1:0];
               r.image_height = height_val[IMGD_W-1:0];
               r.bits_per_pixel = depth_val;
               decoded_results.push_back(r);
               if (!expects) begin
                  end_file(eof);
               end else begin
                  hdr_pos = HDR_LEN;
                  col_idx = 0;
                  row_idx = 0;
                  byte_slot = '0;
                  pad_count = '0;
                  stage = (data_offset == HDR_LEN) ? ST_PIXEL : ST_SKIP;
               end
            end
            ST_SKIP: begin
               hdr_pos = hdr_pos + 1;
               if (eof) post_error(ERR_SHORT_PIX, eof);
               else if (hdr_pos == data_offset) stage = ST_PIXEL;
            end
            ST_PIXEL: begin
               if (byte_slot == 0) begin
                  blue_hold = b;
                  byte_slot = 1;
                  if (eof) post_error(ERR_SHORT_PIX, eof);
                  return;
               end
               if (byte_slot == 1) begin
                  green_hold = b;
                  byte_slot = 2;
                  if (eof) post_error(ERR_SHORT_PIX, eof);
                  return;
               end
               byte_slot = 0;
               last = (col_idx + 1 == width_val) && (row_idx + 1 == height_val);
               if (!last && eof) begin
                  post_error(ERR_SHORT_PIX, eof);
                  return;
               end
               r.kind = KIND_PIXEL;
               r.pixel_column = col_idx[COORD_W-1:0];
               r.pixel_row = COORD_W'(height_val - 1 - row_idx);
               r.blue = blue_hold;
               r.green = green_hold;
               r.red = b;
               r.last_pixel = last;
               decoded_results.push_back(r);
               if (last) begin
                  end_file(eof);
               end else if (col_idx + 1 >= width_val) begin
                  col_idx = 0;
                  row_idx = row_idx + 1;
                  pad_count = width_val[1:0];
                  if (pad_count != 0) stage = ST_PAD;
               end else begin
                  col_idx = col_idx + 1;
               end
            end
            ST_PAD: begin
               if (eof) begin
                  post_error(ERR_SHORT_PIX, eof);
               end else begin
                  pad_count = pad_count - 2'd1;
                  if (pad_count == 0) stage = ST_PIXEL;
               end
            end
            default: begin
               if (eof) clear_state();
            end
         endcase
      endfunction

      function int pending();
         return decoded_results.size();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            fail_count++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (decoded_results.size() == 0) begin
            $error("result item with nothing outstanding: kind %0d", got.kind);
            fail_count++;
            return;
         end
         want = decoded_results.pop_front();
         check_field("kind", 32'(want.kind), 32'(got.kind));
         check_field("error_code", 32'(want.error_code), 32'(got.error_code));
         check_field("image_width", 32'(want.image_width), 32'(got.image_width));
         check_field("image_height", 32'(want.image_height), 32'(got.image_height));
         check_field("bits_per_pixel", 32'(want.bits_per_pixel), 32'(got.bits_per_pixel));
         check_field("pixel_column", 32'(want.pixel_column), 32'(got.pixel_column));
         check_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
         check_field("blue", 32'(want.blue), 32'(got.blue));
         check_field("green", 32'(want.green), 32'(got.green));
         check_field("red", 32'(want.red), 32'(got.red));
         check_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
      endfunction

      function void flag_leftovers();
         if (decoded_results.size() != 0) begin
            $error("%0d result items never arrived", decoded_results.size());
            fail_count++;
         end
      endfunction
   endclass

endpackage

// ===== bench/tb_bmp24_stream_decoder.sv =====
// tb_bmp24_stream_decoder: feeds whole and broken bitmap files byte by byte and checks
// every result item; depends on bmp24_pkg, bmp24_stream_if and bmp24_decode_check_pkg

module tb_bmp24_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bmp24_pkg::*;
   import bmp24_decode_check_pkg::*;

   // receiver hold-off length and the no-progress limit; the limit covers the hold-off
   // several times over, random gaps on either side are short
   localparam int STALL_CYCLES = 300;
   localparam int STUCK_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 250;

   logic clock;
   logic reset;

   bmp24_req_if req_ch ();
   bmp24_rsp_if rsp_ch ();

   bmp24_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bmp_decode_scoreboard sb = new();

   bit gaps_on = 1'b1;           // both sides idle at random while set
   bit stall_request = 1'b0;     // asks the receiver for one long hold-off
   int unsigned bytes_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one item per rising edge at most; results are checked before the new byte is
   // predicted, so a result can never be matched against its own input
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.kind;
            got.error_code = rsp_ch.error_code;
            got.image_width = rsp_ch.image_width;
            got.image_height = rsp_ch.image_height;
            got.bits_per_pixel = rsp_ch.bits_per_pixel;
            got.pixel_column = rsp_ch.pixel_column;
            got.pixel_row = rsp_ch.pixel_row;
            got.blue = rsp_ch.blue;
            got.green = rsp_ch.green;
            got.red = rsp_ch.red;
            got.last_pixel = rsp_ch.last_pixel;
            sb.check_result(got);
         end
         if (req_ch.valid && req_ch.ready)
            sb.decode_byte(req_ch.data_byte, req_ch.end_of_file);
      end
   end

   // watchdog: too many cycles in a row with no item moving on either channel
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: random back-pressure, or one long hold-off on request
   initial begin : receiver
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= 32);
      end
   end

   // offer one byte, starting and ending just after a falling edge; valid stays high
   // from one byte to the next unless a gap falls between them
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic eof);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= value;
      req_ch.end_of_file <= eof;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // the last byte of a file carries end of file
   task automatic send_file(input byte_queue_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   // sender pause until every predicted result has come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // header with random filler, then skip bytes and padded bottom-up rows when the
   // header describes a 24-bit image with a sane offset; pixel bytes lean to 00 and ff
   function automatic void make_bitmap(output byte_queue_type f, input int unsigned w,
                                       input int unsigned h, input logic [BPP_W-1:0] bpp,
                                       input int unsigned offset, input int unsigned comp,
                                       input int unsigned colors);
      int unsigned row_bytes;
      f = {};
      for (int i = 0; i < HDR_LEN; i++) f.push_back(8'($urandom));
      f[0] = SIG_B;
      f[1] = SIG_M;
      for (int k = 0; k < 4; k++) begin
         f[10+k] = offset[8*k +: 8];
         f[18+k] = w[8*k +: 8];
         f[22+k] = h[8*k +: 8];
         f[30+k] = comp[8*k +: 8];
         f[46+k] = colors[8*k +: 8];
      end
      f[28] = bpp[7:0];
      f[29] = bpp[15:8];
      if (bpp == DEPTH_24 && w != 0 && h != 0 && w <= MAX_DIM_DEFAULT
          && h <= MAX_DIM_DEFAULT && offset >= HDR_LEN && offset < HDR_LEN + 64) begin
         repeat (offset - HDR_LEN) f.push_back(8'($urandom));
         row_bytes = 3 * w + (w & 3);
         repeat (h) begin
            for (int j = 0; j < row_bytes; j++)
               f.push_back(($urandom_range(3) == 0) ? {8{$urandom_range(1) == 1}}
                                                    : 8'($urandom));
         end
      end
   endfunction

   initial begin : stimulus
      byte_queue_type f;
      int unsigned w, h, off, comp, colors, sel, n, rand_start, file_idx;
      logic [BPP_W-1:0] bpp;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.end_of_file = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // small image with skip bytes, then ignored bytes after the last pixel
      make_bitmap(f, 3, 2, DEPTH_24, 56, 0, 0);
      f.push_back(8'h00);
      f.push_back(8'hFF);
      send_file(f);

      // bad signature on either byte; the rest is ignored up to end of file
      make_bitmap(f, 2, 2, DEPTH_24, 54, 0, 0);
      f[0] = 8'h58;
      send_file(f);
      make_bitmap(f, 2, 2, DEPTH_24, 54, 0, 0);
      f[1] = 8'h4E;
      send_file(f);

      // file of a single byte: header cut short
      f = {SIG_B};
      send_file(f);

      // compression and palette checks
      make_bitmap(f, 2, 2, DEPTH_24, 54, 1, 0);
      send_file(f);
      make_bitmap(f, 2, 2, DEPTH_24, 54, 0, 256);
      send_file(f);

      // size limit just over the edge, a negative (top-down) height, and the largest
      // allowed size at a depth that emits nothing
      make_bitmap(f, MAX_DIM_DEFAULT + 1, 1, DEPTH_24, 54, 0, 0);
      send_file(f);
      make_bitmap(f, 1, 32'hFFFF_FFFE, DEPTH_24, 54, 0, 0);
      send_file(f);
      make_bitmap(f, MAX_DIM_DEFAULT, MAX_DIM_DEFAULT, 16'd8, 54, 0, 0);
      send_file(f);

      // offset inside the header
      make_bitmap(f, 2, 2, DEPTH_24, 53, 0, 0);
      send_file(f);

      wait_drained();

      // end of file on the last header byte: short pixels at 24 bpp, header otherwise
      make_bitmap(f, 2, 2, DEPTH_24, 54, 0, 0);
      f = f[0:53];
      send_file(f);
      make_bitmap(f, 3, 3, 16'd8, 54, 0, 0);
      f = f[0:53];
      send_file(f);

      // end of file while skipping, inside row padding, and on a non-final pixel
      make_bitmap(f, 2, 2, DEPTH_24, 60, 0, 0);
      f = f[0:56];
      send_file(f);
      make_bitmap(f, 3, 2, DEPTH_24, 54, 0, 0);
      f = f[0:63];
      send_file(f);
      make_bitmap(f, 2, 2, DEPTH_24, 54, 0, 0);
      f = f[0:59];
      send_file(f);

      // zero width, and zero height with an all-ones depth: header only
      make_bitmap(f, 0, 3, DEPTH_24, 54, 0, 0);
      send_file(f);
      make_bitmap(f, 5, 0, 16'hFFFF, 54, 0, 0);
      send_file(f);

      // the tallest image cut off after twenty rows while the receiver holds off, so
      // the decoder fills up and pushes back on its input
      stall_request = 1'b1;
      make_bitmap(f, 1, MAX_DIM_DEFAULT, DEPTH_24, 55, 0, 0);
      f = f[0:134];
      send_file(f);

      // random files: mostly well-formed small images, mixed with broken ones and noise
      rand_start = bytes_sent;
      file_idx = 0;
      while (bytes_sent - rand_start < RANDOM_ITEMS) begin
         gaps_on = !(file_idx >= 1 && file_idx < 5);   // one stretch without idling
         sel = $urandom_range(99);
         if (sel < 55) begin
            // good image, sometimes cut short or with one header byte hit
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            off = ($urandom_range(2) == 0) ? 54 + $urandom_range(1, 6) : 54;
            make_bitmap(f, w, h, DEPTH_24, off, 0, 0);
            if ($urandom_range(99) < 15) begin
               n = $urandom_range(1, f.size());
               f = f[0:n-1];
            end else begin
               repeat ($urandom_range(3)) f.push_back(8'($urandom));
            end
            if ($urandom_range(99) < 8) begin
               n = $urandom_range(0, f.size() - 1);
               if (n > 53) n = 53;
               f[n] = 8'($urandom);
            end
            send_file(f);
         end else if (sel < 67) begin
            // header that announces no pixels
            case ($urandom_range(3))
               0: bpp = 16'd8;
               1: bpp = 16'd32;
               2: bpp = 16'($urandom);
               default: bpp = DEPTH_24;
            endcase
            w = $urandom_range(0, 5);
            h = (bpp == DEPTH_24 && w != 0) ? 0 : $urandom_range(0, 5);
            make_bitmap(f, w, h, bpp, 54 + $urandom_range(0, 3), 0, 0);
            repeat ($urandom_range(4)) f.push_back(8'($urandom));
            send_file(f);
         end else if (sel < 80) begin
            // header errors with random content
            w = $urandom_range(1, 3);
            h = $urandom_range(1, 3);
            off = 54;
            comp = 0;
            colors = 0;
            case ($urandom_range(3))
               0: begin
                  comp = $urandom;
                  if (comp == 0) comp = 1;
               end
               1: begin
                  colors = $urandom;
                  if (colors == 0) colors = 1;
               end
               2: begin
                  if ($urandom_range(1) == 0) w = MAX_DIM_DEFAULT + 1 + $urandom_range(0, 100000);
                  else h = $urandom | 32'h8000_0000;
               end
               default: off = $urandom_range(0, 53);
            endcase
            make_bitmap(f, w, h, DEPTH_24, off, comp, colors);
            send_file(f);
         end else if (sel < 90) begin
            // file that ends within the header
            make_bitmap(f, $urandom_range(1, 4), $urandom_range(1, 4), DEPTH_24, 54, 0, 0);
            n = $urandom_range(1, 54);
            f = f[0:n-1];
            send_file(f);
         end else begin
            // noise, with end of file anywhere in it
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               if (i == 0 && $urandom_range(2) == 0) send_byte(SIG_B, 1'b0);
               else send_byte(8'($urandom), i == n - 1 || $urandom_range(9) == 0);
            end
         end
         if ($urandom_range(9) == 0) wait_drained();
         file_idx++;
      end

      gaps_on = 1'b1;
      wait_drained();
      repeat (8) @(negedge clock);
      sb.flag_leftovers();
      if (sb.fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bmp24_pkg.sv
rtl/bmp24_stream_if.sv
rtl/bmp24_in_stage.sv
rtl/bmp24_decode.sv
rtl/bmp24_stream_decoder.sv
bench/bmp24_decode_check_pkg.sv
bench/tb_bmp24_stream_decoder.sv
